### design/ngga_pkg.sv
// ----------------------------------------------------------------------------
// ngga_pkg: shared types and constants for the GGA sentence capture unit
// Parser state encoding, character codes and the valid-character test.
// ----------------------------------------------------------------------------
package ngga_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChStar   = 8'h2A;

  typedef enum logic [8:0] {
    StInit    = 9'b0_0000_0001,
    StWait    = 9'b0_0000_0010,
    StHdrG1   = 9'b0_0000_0100,
    StHdrP    = 9'b0_0000_1000,
    StHdrG2   = 9'b0_0001_0000,
    StHdrG3   = 9'b0_0010_0000,
    StHdrA    = 9'b0_0100_0000,
    StHdrComma = 9'b0_1000_0000,
    StCapture = 9'b1_0000_0000
  } parser_state_e;

  typedef struct packed {
    logic [6:0] payload_position;
    logic [7:0] payload_byte;
  } result_t;

  // Letters, digits and the NMEA punctuation we care about.
  function automatic logic char_is_valid(input logic [7:0] c);
    logic upper, lower, digit;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return upper || lower || digit || (c == ChComma) || (c == ChDollar) ||
           (c == ChDot) || (c == ChStar);
  endfunction

endpackage

### design/nmea_gga_sentence_capture_unit.sv
// Takes one received byte per clock while the result register is free or
// being drained and, once "$GPGGA," has been matched, forwards every following
// valid character with its payload index. Thus the unit sustains one input
// transaction per cycle; a result appears on the master side in the cycle
// after its byte is accepted, held in a single output register. The slave side
// stalls while that register is full and the consumer stalls. Invalid
// characters and bytes taken while capture_enable is low produce nothing.
// ----------------------------------------------------------------------------
// nmea_gga_sentence_capture_unit: GGA sentence filter
// Header matcher, payload position counter and registered result stage.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_capture_unit #(
  parameter int unsigned PAYLOAD_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel: bit 0 = capture_enable
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [14:8] payload_position, [15] 0
  output logic        m_axis_tlast,   // sentence_end
  output logic        m_axis_tuser    // position_overflow
);
  import ngga_pkg::*;

  localparam int unsigned CntW   = $clog2(PAYLOAD_DEPTH + 1);
  localparam int unsigned MaxPos = (PAYLOAD_DEPTH - 1 > 127) ? 127 : PAYLOAD_DEPTH - 1;

  logic          enable_q;
  parser_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  logic    last_q, last_d;
  logic    ovf_q, ovf_d;

  logic       accept, active, emit, ovf;
  logic [7:0] c;
  logic [6:0] pos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;
  assign active        = accept && enable_q && char_is_valid(c);

  assign ovf = (count_q >= CntW'(PAYLOAD_DEPTH));
  assign pos = (count_q > CntW'(MaxPos)) ? 7'(MaxPos) : 7'(count_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    emit    = 1'b0;
    if (active) begin
      unique case (state_q)
        StInit: begin
          state_d = StWait;
          count_d = '0;
        end
        StWait:    if (c == ChDollar) state_d = StHdrG1;
        StHdrG1:   state_d = (c == ChG)     ? StHdrP     : StWait;
        StHdrP:    state_d = (c == ChP)     ? StHdrG2    : StWait;
        StHdrG2:   state_d = (c == ChG)     ? StHdrG3    : StWait;
        StHdrG3:   state_d = (c == ChG)     ? StHdrA     : StWait;
        StHdrA:    state_d = (c == ChA)     ? StHdrComma : StWait;
        StHdrComma: begin
          if (c == ChComma) begin
            state_d = StCapture;
            count_d = '0;
          end else begin
            state_d = StWait;
          end
        end
        StCapture: begin
          emit = 1'b1;
          if (!ovf) count_d = count_q + CntW'(1);
          if (c == ChDollar) state_d = StWait;
        end
        default:   state_d = StWait;
      endcase
    end
  end

  // Load the result register on emit, drain it when the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      res_d.payload_byte     = c;
      res_d.payload_position = pos;
      last_d               = (c == ChDollar);
      ovf_d                = ovf;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      state_q     <= StInit;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) enable_q <= cfg_data_i;
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = ovf_q;

endmodule

### design/ngga_checker.sv
// ----------------------------------------------------------------------------
// ngga_checker: port-level checks for the GGA sentence capture unit
// Watches the stream ports and flags handshake and payload slips.
// ----------------------------------------------------------------------------
module ngga_checker #(
  parameter int unsigned PAYLOAD_DEPTH = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  import ngga_pkg::*;

  localparam int unsigned MaxPos = (PAYLOAD_DEPTH - 1 > 127) ? 127 : PAYLOAD_DEPTH - 1;

  // hold a stalled result transaction
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_last_dollar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == ChDollar)
    else $error("sentence end on a byte other than '$'");

  a_ovf_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[14:8] == 7'(MaxPos))
    else $error("overflow without position held at maximum");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while result stage can take data");

endmodule

bind nmea_gga_sentence_capture_unit ngga_checker #(
  .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
) u_ngga_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/nmea_gga_sentence_capture_unit_test.sv
// ----------------------------------------------------------------------------
// nmea_gga_sentence_capture_unit_test: self-checking bench for the GGA filter
// Streams byte traffic into the unit: header matches, broken headers, noise,
// long payloads and runs with capture disabled. Each accepted byte is run
// through a behavioral parser, and every payload result leaving the unit is
// compared field by field with the oldest prediction. Both stream sides idle
// and stall at random, with one long consumer hold-off.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_capture_unit_test;
  import ngga_pkg::*;

  localparam int unsigned PAYLOAD_DEPTH = 128;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [6:0] payload_position;
    logic       sentence_end;
    logic       position_overflow;
  } gga_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  nmea_gga_sentence_capture_unit #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [7:0]    rx_bytes_pending[$];
  gga_result_t   payload_expected[$];
  int            fail_count = 0;
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            rx_hold_left = 0;
  int            valid_bytes_queued = 0;
  bit            byte_taken = 1'b0;

  // Parser mirror
  bit            gga_enable = 1'b1;
  parser_state_e gga_state = StInit;
  logic [7:0]    gga_count = 8'd0;

  function automatic logic is_nmea_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == ChComma || c == ChDollar ||
           c == ChDot || c == ChStar;
  endfunction

  // Advance the parser mirror by one accepted byte; queue any payload result.
  function automatic void gga_track_byte(input logic [7:0] c);
    logic [7:0]  hdr_char;
    gga_result_t res;
    if (!gga_enable || !is_nmea_char(c)) return;
    case (gga_state)
      StInit: begin
        gga_state = StWait;
        gga_count = 8'd0;
      end
      StWait: begin
        if (c == ChDollar) gga_state = StHdrG1;
      end
      StCapture: begin
        res.payload_byte      = c;
        res.position_overflow = (gga_count >= PAYLOAD_DEPTH);
        res.payload_position  = (gga_count > PAYLOAD_DEPTH - 1) ? 7'(PAYLOAD_DEPTH - 1)
                                                                 : gga_count[6:0];
        res.sentence_end      = (c == ChDollar);
        if (!res.position_overflow) gga_count = gga_count + 8'd1;
        if (c == ChDollar) gga_state = StWait;
        payload_expected.push_back(res);
      end
      StHdrG1, StHdrP, StHdrG2, StHdrG3, StHdrA, StHdrComma: begin
        case (gga_state)
          StHdrP:     hdr_char = ChP;
          StHdrA:     hdr_char = ChA;
          StHdrComma: hdr_char = ChComma;
          default:    hdr_char = ChG;
        endcase
        if (c != hdr_char) begin
          gga_state = StWait;
        end else begin
          case (gga_state)
            StHdrG1: gga_state = StHdrP;
            StHdrP:  gga_state = StHdrG2;
            StHdrG2: gga_state = StHdrG3;
            StHdrG3: gga_state = StHdrA;
            StHdrA:  gga_state = StHdrComma;
            default: begin
              gga_state = StCapture;
              gga_count = 8'd0;
            end
          endcase
        end
      end
      default: gga_state = StWait;
    endcase
  endfunction

  // Sender: hold the offered byte until its transaction completes.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || byte_taken) begin
      if (rx_bytes_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_bytes_pending.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off when requested, random stalls otherwise.
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    byte_taken = s_axis_tvalid && s_axis_tready;
    if (byte_taken) gga_track_byte(s_axis_tdata);
  end

  always @(posedge clk_i) begin
    gga_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (payload_expected.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual data=%h last=%b user=%b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = payload_expected.pop_front();
        if (m_axis_tdata[7:0] !== want.payload_byte ||
            m_axis_tdata[14:8] !== want.payload_position ||
            m_axis_tdata[15] !== 1'b0 ||
            m_axis_tlast !== want.sentence_end ||
            m_axis_tuser !== want.position_overflow) begin
          fail_count++;
          $display("%0t: mismatch: expected byte=%h pos=%0d last=%b ovf=%b, actual byte=%h pos=%0d pad=%b last=%b ovf=%b",
                   $time, want.payload_byte, want.payload_position, want.sentence_end,
                   want.position_overflow, m_axis_tdata[7:0], m_axis_tdata[14:8],
                   m_axis_tdata[15], m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    if (is_nmea_char(b)) valid_bytes_queued++;
  endtask

  function automatic logic [7:0] pick_payload_char();
    int r;
    r = $urandom_range(0, 64);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62) return ChComma;
    if (r == 63) return ChDot;
    return ChStar;
  endfunction

  function automatic logic [7:0] pick_junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_nmea_char(b));
    return b;
  endfunction

  task automatic queue_header(input int good_chars);
    logic [7:0] hdr[6];
    hdr = '{ChG, ChP, ChG, ChG, ChA, ChComma};
    queue_byte(ChDollar);
    for (int i = 0; i < good_chars; i++) queue_byte(hdr[i]);
  endtask

  task automatic queue_sentence(input int len, input bit noisy);
    queue_header(6);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 3) == 0) queue_byte(pick_junk_byte());
      queue_byte(pick_payload_char());
    end
    queue_byte(ChDollar);
  endtask

  task automatic queue_random_traffic(input int n);
    int start;
    int r;
    start = valid_bytes_queued;
    while (valid_bytes_queued - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        queue_sentence($urandom_range(120, 200), 1'b0);
      end else if (r < 65) begin
        queue_sentence($urandom_range(0, 30), 1'b0);
      end else if (r < 75) begin
        queue_sentence($urandom_range(0, 30), 1'b1);
      end else if (r < 88) begin
        // header cut short, followed by a random payload character or '$'
        queue_header($urandom_range(0, 5));
        queue_byte($urandom_range(0, 1) ? pick_payload_char() : ChDollar);
      end else begin
        repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (rx_bytes_pending.size() > 0 || s_axis_tvalid || payload_expected.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capture_enable(input bit value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    gga_enable = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] directed[$];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_capture_enable(1'b1);

    // Out-of-range bytes, the first valid byte swallowed, then a sentence
    // carrying every character class, and an ending '$' that does not rearm.
    directed = '{8'h00, 8'hFF, ChDollar, ChDollar, ChG, ChP, ChG, ChG, ChA, ChComma,
                 "0", "9", "A", "Z", "a", "z", ChDot, ChStar, ChComma, 8'h80, 8'h7F,
                 ChDollar, ChG, ChP, ChComma};
    foreach (directed[i]) queue_byte(directed[i]);
    wait_drained();

    // Disabled in the middle of a payload: everything dropped, then resume.
    queue_header(6);
    queue_byte("1");
    wait_drained();
    write_capture_enable(1'b0);
    queue_sentence(5, 1'b0);
    queue_byte("x");
    wait_drained();
    write_capture_enable(1'b1);
    queue_byte("2");
    queue_byte(ChDollar);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    queue_random_traffic(400);
    @(posedge clk_i);
    rx_hold_left = 300;
    wait_drained();

    tx_idle_pct  = 51;
    rx_stall_pct = 0;
    queue_random_traffic(400);
    wait_drained();

    write_capture_enable(1'b0);
    queue_random_traffic(40);
    wait_drained();
    write_capture_enable(1'b1);

    tx_idle_pct  = 0;
    rx_stall_pct = 51;
    queue_random_traffic(400);
    wait_drained();

    tx_idle_pct  = 36;
    rx_stall_pct = 36;
    queue_random_traffic(400);
    wait_drained();

    if (fail_count == 0 && payload_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
